// ----- rtl/core/fsp_pkg.sv -----
package fsp_pkg;

    // Flag bit positions in flag_bits
    localparam int unsigned FbZeropad = 0;
    localparam int unsigned FbLeft    = 1;
    localparam int unsigned FbHash    = 2;
    localparam int unsigned FbSpace   = 3;
    localparam int unsigned FbPlus    = 4;
    localparam int unsigned FbPrec    = 5;
    localparam int unsigned FbSigned  = 6;

    // Length codes
    localparam logic [2:0] LenNone = 3'd0;
    localparam logic [2:0] LenH    = 3'd1;
    localparam logic [2:0] LenHh   = 3'd2;
    localparam logic [2:0] LenL    = 3'd3;
    localparam logic [2:0] LenLl   = 3'd4;

    // Characters of the format syntax
    localparam logic [7:0] ChZero    = 8'h30;
    localparam logic [7:0] ChNine    = 8'h39;
    localparam logic [7:0] ChMinus   = 8'h2d;
    localparam logic [7:0] ChHash    = 8'h23;
    localparam logic [7:0] ChSpace   = 8'h20;
    localparam logic [7:0] ChPlus    = 8'h2b;
    localparam logic [7:0] ChStar    = 8'h2a;
    localparam logic [7:0] ChDot     = 8'h2e;
    localparam logic [7:0] ChLowL    = 8'h6c;
    localparam logic [7:0] ChLowH    = 8'h68;
    localparam logic [7:0] ChLowC    = 8'h63;
    localparam logic [7:0] ChLowS    = 8'h73;
    localparam logic [7:0] ChLowP    = 8'h70;
    localparam logic [7:0] ChLowD    = 8'h64;
    localparam logic [7:0] ChLowI    = 8'h69;
    localparam logic [7:0] ChLowU    = 8'h75;
    localparam logic [7:0] ChLowX    = 8'h78;
    localparam logic [7:0] ChUpX     = 8'h58;
    localparam logic [7:0] ChPercent = 8'h25;

    typedef struct packed {
        logic [7:0]         ch;
        logic signed [31:0] star_value;
        logic               first_char;
    } t_fsp_in;

    typedef struct packed {
        logic [6:0]  flag_bits;
        logic [15:0] field_width;
        logic [15:0] precision_value;
        logic [2:0]  length_code;
        logic [7:0]  conversion;
        logic        spec_valid;
        logic        char_consumed;
    } t_fsp_out;

endpackage

// ----- rtl/core/fsp_stream_if.sv -----
interface fsp_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/core/fsp_sat_acc.sv -----
module fsp_sat_acc #(
    parameter int unsigned COUNT_BITS = 16
) (
    input  logic [COUNT_BITS-1:0] i_acc,
    input  logic [3:0]            i_digit,
    input  logic [31:0]           i_star_mag,
    output logic [COUNT_BITS-1:0] o_digit_acc,
    output logic [COUNT_BITS-1:0] o_star_acc
);
    localparam int unsigned WideBits = COUNT_BITS + 4;
    localparam logic [WideBits-1:0] WideMax = {4'b0, {COUNT_BITS{1'b1}}};
    localparam logic [31:0] MagMax = 32'({COUNT_BITS{1'b1}});

    logic [WideBits-1:0] acc_ext;
    logic [WideBits-1:0] wide;

    // acc * 10 + digit as shift-add, then saturate
    assign acc_ext = {4'b0, i_acc};
    assign wide = (acc_ext << 3) + (acc_ext << 1) + WideBits'(i_digit);
    assign o_digit_acc = (wide > WideMax) ? {COUNT_BITS{1'b1}} : wide[COUNT_BITS-1:0];

    // Saturate the star magnitude to the count range
    assign o_star_acc = (i_star_mag > MagMax) ? {COUNT_BITS{1'b1}}
                                              : i_star_mag[COUNT_BITS-1:0];
endmodule

// ----- rtl/core/format_spec_parser.sv -----
// Streaming printf conversion-specification parser. Feed the characters that
// follow a percent sign one beat at a time; first_char clears any partial
// specification. Flags, width, precision (digits or star argument) and length
// are gathered until a specifier, a NUL or an unknown character ends the
// specification; that beat produces one result beat and the parser starts
// over. Throughput is one character per cycle unless the input is held off:
// the next state is formed from the current state, the critical path being
// the saturating multiply-by-ten accumulate. Results come out of a register
// in the cycle after the ending character. While a result beat waits and the
// output is not ready, the input is held off; a result taken in the same cycle
// frees the register at once, so a steady sink sees no gaps.
// Counts saturate at 2**COUNT_BITS-1 and the low 16 bits are reported.
module format_spec_parser #(
    parameter int unsigned COUNT_BITS = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    fsp_stream_if.sink   i_in,
    fsp_stream_if.source o_out
);
    import fsp_pkg::*;

    localparam logic [2:0] PhFlags  = 3'd0;
    localparam logic [2:0] PhWdig   = 3'd1;
    localparam logic [2:0] PhPrec   = 3'd2;
    localparam logic [2:0] PhDot    = 3'd3;
    localparam logic [2:0] PhPdig   = 3'd4;
    localparam logic [2:0] PhLen    = 3'd5;
    localparam logic [2:0] PhSecond = 3'd6;
    localparam logic [2:0] PhSpec   = 3'd7;

    logic [2:0]            r_phase, n_phase;
    logic [6:0]            r_flag, n_flag;
    logic [COUNT_BITS-1:0] r_width, n_width;
    logic [COUNT_BITS-1:0] r_prec, n_prec;
    logic [2:0]            r_len, n_len;
    t_fsp_out              r_out, n_out;
    logic                  r_out_valid;

    logic [2:0]            st_phase;
    logic [6:0]            st_flag;
    logic [COUNT_BITS-1:0] st_width;
    logic [COUNT_BITS-1:0] st_prec;
    logic [2:0]            st_len;

    logic [7:0]            ch;
    logic [31:0]           sv;
    logic                  neg;
    logic [31:0]           mag;
    logic                  is_dig;
    logic [3:0]            digit;
    logic [COUNT_BITS-1:0] digit_ext;
    logic [COUNT_BITS-1:0] w_digit_acc, w_star_acc;
    logic [COUNT_BITS-1:0] p_digit_acc, p_star_acc;
    logic [15:0]           width16, prec16;
    logic                  emit;
    logic                  accept;

    // Decode the input beat
    assign ch        = i_in.data.ch;
    assign sv        = i_in.data.star_value;
    assign neg       = sv[31];
    assign mag       = neg ? (~sv + 32'd1) : sv;
    assign is_dig    = (ch >= ChZero) && (ch <= ChNine);
    assign digit     = is_dig ? 4'(ch - ChZero) : 4'd0;
    assign digit_ext = COUNT_BITS'(digit);

    // Start from cleared state on the first character
    always_comb begin
        if (i_in.data.first_char) begin
            st_phase = PhFlags;
            st_flag  = '0;
            st_width = '0;
            st_prec  = '0;
            st_len   = LenNone;
        end else begin
            st_phase = r_phase;
            st_flag  = r_flag;
            st_width = r_width;
            st_prec  = r_prec;
            st_len   = r_len;
        end
    end

    fsp_sat_acc #(.COUNT_BITS(COUNT_BITS)) u_width_acc (
        .i_acc       (st_width),
        .i_digit     (digit),
        .i_star_mag  (mag),
        .o_digit_acc (w_digit_acc),
        .o_star_acc  (w_star_acc)
    );

    fsp_sat_acc #(.COUNT_BITS(COUNT_BITS)) u_prec_acc (
        .i_acc       (st_prec),
        .i_digit     (digit),
        .i_star_mag  (mag),
        .o_digit_acc (p_digit_acc),
        .o_star_acc  (p_star_acc)
    );

    // Report the low 16 bits of the counts
    generate
        if (COUNT_BITS >= 16) begin : g_wide_count
            assign width16 = st_width[15:0];
            assign prec16  = st_prec[15:0];
        end else begin : g_narrow_count
            assign width16 = {{(16 - COUNT_BITS){1'b0}}, st_width};
            assign prec16  = {{(16 - COUNT_BITS){1'b0}}, st_prec};
        end
    endgenerate

    // Walk the phases; a character that does not fit falls through
    always_comb begin
        logic [2:0] p;
        logic       done;
        logic       spec_ok;
        logic [6:0] res_flag;

        n_phase  = st_phase;
        n_flag   = st_flag;
        n_width  = st_width;
        n_prec   = st_prec;
        n_len    = st_len;
        p        = st_phase;
        done     = 1'b0;
        spec_ok  = 1'b1;
        res_flag = st_flag;
        emit     = 1'b0;
        n_out    = '0;

        // Flags and width
        if (p == PhFlags) begin
            done = 1'b1;
            priority if (ch == ChZero) begin
                n_flag[FbZeropad] = 1'b1;
            end else if (ch == ChMinus) begin
                n_flag[FbLeft] = 1'b1;
            end else if (ch == ChHash) begin
                n_flag[FbHash] = 1'b1;
            end else if (ch == ChSpace) begin
                n_flag[FbSpace] = 1'b1;
            end else if (ch == ChPlus) begin
                n_flag[FbPlus] = 1'b1;
            end else if (is_dig) begin
                n_width = digit_ext;
                n_phase = PhWdig;
            end else if (ch == ChStar) begin
                if (neg) begin
                    n_flag[FbLeft] = 1'b1;
                end
                n_width = w_star_acc;
                n_phase = PhPrec;
            end else begin
                done = 1'b0;
                p    = PhPrec;
            end
        end else if (p == PhWdig) begin
            if (is_dig) begin
                n_width = w_digit_acc;
                done    = 1'b1;
            end else begin
                p = PhPrec;
            end
        end

        // Precision
        if (!done) begin
            if (p == PhPrec) begin
                if (ch == ChDot) begin
                    n_flag[FbPrec] = 1'b1;
                    n_prec  = '0;
                    n_phase = PhDot;
                    done    = 1'b1;
                end else begin
                    p = PhLen;
                end
            end else if (p == PhDot) begin
                if (is_dig) begin
                    n_prec  = digit_ext;
                    n_phase = PhPdig;
                    done    = 1'b1;
                end else if (ch == ChStar) begin
                    if (neg) begin
                        n_flag[FbPrec] = 1'b0;
                        n_prec = '0;
                    end else begin
                        n_prec = p_star_acc;
                    end
                    n_phase = PhLen;
                    done    = 1'b1;
                end else begin
                    p = PhLen;
                end
            end else if (p == PhPdig) begin
                if (is_dig) begin
                    n_prec = p_digit_acc;
                    done   = 1'b1;
                end else begin
                    p = PhLen;
                end
            end
        end

        // Length modifier
        if (!done) begin
            if (p == PhLen) begin
                if (ch == ChLowL || ch == ChLowH) begin
                    n_len   = (ch == ChLowL) ? LenL : LenH;
                    n_phase = PhSecond;
                    done    = 1'b1;
                end
            end else if (p == PhSecond) begin
                if (ch == ChLowL && st_len == LenL) begin
                    n_len   = LenLl;
                    n_phase = PhSpec;
                    done    = 1'b1;
                end else if (ch == ChLowH && st_len == LenH) begin
                    n_len   = LenHh;
                    n_phase = PhSpec;
                    done    = 1'b1;
                end
            end
        end

        // Specifier ends the parse, valid or not
        if (!done) begin
            priority if (ch == ChLowC) begin
                res_flag[FbPrec] = 1'b1;
            end else if (ch == ChLowP) begin
                res_flag[FbHash] = 1'b1;
            end else if (ch == ChLowD || ch == ChLowI) begin
                res_flag[FbSigned] = 1'b1;
                res_flag[FbHash]   = 1'b0;
            end else if (ch == ChLowU) begin
                res_flag[FbHash] = 1'b0;
            end else if (ch == ChLowS || ch == ChLowX || ch == ChUpX
                         || ch == ChPercent) begin
                res_flag = st_flag;
            end else begin
                spec_ok = 1'b0;
            end

            emit                  = 1'b1;
            n_out.flag_bits       = res_flag;
            n_out.field_width     = width16;
            n_out.precision_value = res_flag[FbPrec] ? prec16 : 16'd0;
            n_out.length_code     = st_len;
            n_out.conversion      = ch;
            n_out.spec_valid      = spec_ok;
            n_out.char_consumed   = spec_ok;

            n_phase = PhFlags;
            n_flag  = '0;
            n_width = '0;
            n_prec  = '0;
            n_len   = LenNone;
        end
    end

    // Accept while the result register is free or draining
    assign i_in.ready = !r_out_valid || o_out.ready;
    assign accept     = i_in.valid && i_in.ready;

    // Advance the parse state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PhFlags;
            r_flag  <= '0;
            r_width <= '0;
            r_prec  <= '0;
            r_len   <= LenNone;
        end else if (accept) begin
            r_phase <= n_phase;
            r_flag  <= n_flag;
            r_width <= n_width;
            r_prec  <= n_prec;
            r_len   <= n_len;
        end
    end

    // Hold the result beat until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept && emit) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && emit) begin
            r_out <= n_out;
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;
endmodule

// ----- tb/sv/fsp_spec_monitor.sv -----
module fsp_spec_monitor #(
    parameter int unsigned COUNT_BITS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_ready,
    input  fsp_pkg::t_fsp_in  i_in_beat,
    input  logic              i_out_valid,
    input  logic              i_out_ready,
    input  fsp_pkg::t_fsp_out i_out_beat,
    output int unsigned       o_fail_count,
    output int unsigned       o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import fsp_pkg::*;

    typedef enum logic [2:0] {
        PhFlags,
        PhWidthDigits,
        PhPrecDot,
        PhAfterDot,
        PhPrecDigits,
        PhLength,
        PhSecondLen,
        PhSpecifier
    } t_parse_phase;

    localparam logic [63:0] CountMax = (64'd1 << COUNT_BITS) - 64'd1;

    // Parser state as the block should hold it
    t_parse_phase phase_q;
    logic [6:0]   flags_q;
    logic [63:0]  width_q;
    logic [63:0]  prec_q;
    logic [2:0]   length_q;

    t_fsp_out     expected_specs[$];
    int unsigned  mismatches;
    int unsigned  results_seen;

    function automatic void clear_spec();
        phase_q  = PhFlags;
        flags_q  = '0;
        width_q  = '0;
        prec_q   = '0;
        length_q = LenNone;
    endfunction

    function automatic logic [63:0] saturate_count(input logic [63:0] v);
        return (v > CountMax) ? CountMax : v;
    endfunction

    // Advance the parse by one character; flag a finished specification
    function automatic void parse_char(input t_fsp_in beat, output bit ends,
                                       output t_fsp_out res);
        logic [7:0]   c;
        logic [31:0]  sv;
        logic [31:0]  mag;
        logic         neg;
        logic         is_digit;
        logic [63:0]  digit;
        logic         spec_ok;
        t_parse_phase p;
        c        = beat.ch;
        sv       = beat.star_value;
        neg      = sv[31];
        mag      = neg ? (~sv + 32'd1) : sv;
        is_digit = (c >= ChZero) && (c <= ChNine);
        digit    = is_digit ? 64'(c - ChZero) : 64'd0;
        ends     = 1'b0;
        res      = '0;
        if (beat.first_char) begin
            clear_spec();
        end
        p = phase_q;

        // Flags, then width digits or a width star
        if (p == PhFlags) begin
            case (c)
                ChZero: begin
                    flags_q[FbZeropad] = 1'b1;
                    return;
                end
                ChMinus: begin
                    flags_q[FbLeft] = 1'b1;
                    return;
                end
                ChHash: begin
                    flags_q[FbHash] = 1'b1;
                    return;
                end
                ChSpace: begin
                    flags_q[FbSpace] = 1'b1;
                    return;
                end
                ChPlus: begin
                    flags_q[FbPlus] = 1'b1;
                    return;
                end
                default: ;
            endcase
            if (is_digit) begin
                width_q = digit;
                phase_q = PhWidthDigits;
                return;
            end
            if (c == ChStar) begin
                if (neg) begin
                    flags_q[FbLeft] = 1'b1;
                end
                width_q = saturate_count(64'(mag));
                phase_q = PhPrecDot;
                return;
            end
            p = PhPrecDot;
        end else if (p == PhWidthDigits) begin
            if (is_digit) begin
                width_q = saturate_count(width_q * 64'd10 + digit);
                return;
            end
            p = PhPrecDot;
        end

        // Precision: dot, then digits or a star
        if (p == PhPrecDot) begin
            if (c == ChDot) begin
                flags_q[FbPrec] = 1'b1;
                prec_q  = '0;
                phase_q = PhAfterDot;
                return;
            end
            p = PhLength;
        end else if (p == PhAfterDot) begin
            if (is_digit) begin
                prec_q  = digit;
                phase_q = PhPrecDigits;
                return;
            end
            if (c == ChStar) begin
                if (neg) begin
                    flags_q[FbPrec] = 1'b0;
                    prec_q = '0;
                end else begin
                    prec_q = saturate_count(64'(mag));
                end
                phase_q = PhLength;
                return;
            end
            p = PhLength;
        end else if (p == PhPrecDigits) begin
            if (is_digit) begin
                prec_q = saturate_count(prec_q * 64'd10 + digit);
                return;
            end
            p = PhLength;
        end

        // Length modifier, second letter doubles it
        if (p == PhLength) begin
            if (c == ChLowL || c == ChLowH) begin
                length_q = (c == ChLowL) ? LenL : LenH;
                phase_q  = PhSecondLen;
                return;
            end
        end else if (p == PhSecondLen) begin
            if (c == ChLowL && length_q == LenL) begin
                length_q = LenLl;
                phase_q  = PhSpecifier;
                return;
            end
            if (c == ChLowH && length_q == LenH) begin
                length_q = LenHh;
                phase_q  = PhSpecifier;
                return;
            end
        end

        // Conversion character ends the specification
        spec_ok = 1'b1;
        case (c)
            ChLowC: flags_q[FbPrec] = 1'b1;
            ChLowP: flags_q[FbHash] = 1'b1;
            ChLowD, ChLowI: begin
                flags_q[FbSigned] = 1'b1;
                flags_q[FbHash]   = 1'b0;
            end
            ChLowU: flags_q[FbHash] = 1'b0;
            ChLowS, ChLowX, ChUpX, ChPercent: ;
            default: spec_ok = 1'b0;
        endcase

        res.flag_bits       = flags_q;
        res.field_width     = width_q[15:0];
        res.precision_value = flags_q[FbPrec] ? prec_q[15:0] : 16'd0;
        res.length_code     = length_q;
        res.conversion      = c;
        res.spec_valid      = spec_ok;
        res.char_consumed   = spec_ok;
        ends = 1'b1;
        clear_spec();
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t: result %0d: %s got %0h expected %0h",
                 $realtime, results_seen, what, got, want);
        mismatches++;
    endtask

    // Compare result beats first: they can only stem from earlier characters
    always @(posedge i_clk) begin
        t_fsp_out want;
        t_fsp_out predicted;
        bit       ends;
        if (!i_rst_n) begin
            clear_spec();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (expected_specs.size() == 0) begin
                    report_mismatch("result with nothing pending, conversion",
                                    32'(i_out_beat.conversion), 32'd0);
                end else begin
                    want = expected_specs.pop_front();
                    if (i_out_beat.flag_bits !== want.flag_bits)
                        report_mismatch("flag_bits", 32'(i_out_beat.flag_bits),
                                        32'(want.flag_bits));
                    if (i_out_beat.field_width !== want.field_width)
                        report_mismatch("field_width", 32'(i_out_beat.field_width),
                                        32'(want.field_width));
                    if (i_out_beat.precision_value !== want.precision_value)
                        report_mismatch("precision_value",
                                        32'(i_out_beat.precision_value),
                                        32'(want.precision_value));
                    if (i_out_beat.length_code !== want.length_code)
                        report_mismatch("length_code", 32'(i_out_beat.length_code),
                                        32'(want.length_code));
                    if (i_out_beat.conversion !== want.conversion)
                        report_mismatch("conversion", 32'(i_out_beat.conversion),
                                        32'(want.conversion));
                    if (i_out_beat.spec_valid !== want.spec_valid)
                        report_mismatch("spec_valid", 32'(i_out_beat.spec_valid),
                                        32'(want.spec_valid));
                    if (i_out_beat.char_consumed !== want.char_consumed)
                        report_mismatch("char_consumed", 32'(i_out_beat.char_consumed),
                                        32'(want.char_consumed));
                end
                results_seen++;
            end
            if (i_in_valid && i_in_ready) begin
                parse_char(i_in_beat, ends, predicted);
                if (ends) begin
                    expected_specs.push_back(predicted);
                end
            end
        end
        o_fail_count <= mismatches;
        o_pending    <= expected_specs.size();
    end

endmodule

// ----- tb/sv/tb_format_spec_parser.sv -----
module tb_format_spec_parser;
    timeunit 1ns;
    timeprecision 1ps;

    import fsp_pkg::*;

    localparam int unsigned CountBits     = 16;
    localparam int unsigned HoldOffCycles = 300;
    localparam int unsigned WatchdogLimit = 2000;
    localparam int unsigned TailCycles    = 20;
    localparam int unsigned PhaseItems    = 105;
    localparam logic [7:0]  ChNul         = 8'h00;

    logic        clk;
    logic        rst_n;
    int unsigned fail_count;
    int unsigned pending;
    int unsigned items_sent;
    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;
    int unsigned pressure_requests;
    int unsigned stuck_cycles;

    fsp_stream_if #(.T(t_fsp_in))  in_if ();
    fsp_stream_if #(.T(t_fsp_out)) out_if ();

    format_spec_parser #(
        .COUNT_BITS(CountBits)
    ) dut (
        .i_clk  (clk),
        .i_rst_n(rst_n),
        .i_in   (in_if),
        .o_out  (out_if)
    );

    fsp_spec_monitor #(
        .COUNT_BITS(CountBits)
    ) spec_check (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_if.valid),
        .i_in_ready  (in_if.ready),
        .i_in_beat   (in_if.data),
        .i_out_valid (out_if.valid),
        .i_out_ready (out_if.ready),
        .i_out_beat  (out_if.data),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Result side: random stalls, plus one long hold-off on request
    initial begin
        int unsigned pressure_served;
        int unsigned held;
        pressure_served = 0;
        out_if.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (pressure_requests != pressure_served) begin
                pressure_served++;
                out_if.ready <= 1'b0;
                for (held = 0; held < HoldOffCycles; held++) begin
                    @(posedge clk);
                end
            end
            out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Abort when no beat moves on either side for too long
    always @(posedge clk) begin
        if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
            stuck_cycles <= 0;
        end else if (stuck_cycles >= WatchdogLimit) begin
            $display("tb_format_spec_parser: FAIL");
            $finish;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    // Offer one character beat, idling at random first, and hold until taken
    task automatic send_beat(input t_fsp_in beat);
        while ($urandom_range(99) < send_idle_pct) begin
            in_if.valid <= 1'b0;
            @(posedge clk);
        end
        in_if.valid <= 1'b1;
        in_if.data  <= beat;
        @(posedge clk);
        while (!in_if.ready) begin
            @(posedge clk);
        end
        items_sent++;
    endtask

    task automatic send_text(input string text, input logic [31:0] star);
        t_fsp_in beat;
        for (int i = 0; i < text.len(); i++) begin
            beat.ch         = text[i];
            beat.star_value = star;
            beat.first_char = (i == 0);
            send_beat(beat);
        end
    endtask

    function automatic logic [31:0] random_star();
        case ($urandom_range(5))
            0:       return $urandom;
            1:       return -$urandom_range(1, 100);
            2:       return $urandom_range(70000);
            3:       return 32'h8000_0000;
            4:       return 32'h7fff_ffff;
            default: return 32'hffff_ffff;
        endcase
    endfunction

    function automatic logic [7:0] random_flag();
        case ($urandom_range(4))
            0:       return ChZero;
            1:       return ChMinus;
            2:       return ChHash;
            3:       return ChSpace;
            default: return ChPlus;
        endcase
    endfunction

    function automatic logic [7:0] random_specifier();
        case ($urandom_range(8))
            0:       return ChLowC;
            1:       return ChLowS;
            2:       return ChLowP;
            3:       return ChLowD;
            4:       return ChLowI;
            5:       return ChLowU;
            6:       return ChLowX;
            7:       return ChUpX;
            default: return ChPercent;
        endcase
    endfunction

    // Build a mostly well-formed specification with random content, then break some
    task automatic send_random_spec();
        logic [7:0] text[$];
        t_fsp_in    beat;
        repeat ($urandom_range(3)) text.push_back(random_flag());
        case ($urandom_range(3))
            1: begin
                text.push_back(8'(ChZero + $urandom_range(1, 9)));
                repeat ($urandom_range(5)) text.push_back(8'(ChZero + $urandom_range(9)));
            end
            2: text.push_back(ChStar);
            default: ;
        endcase
        case ($urandom_range(3))
            1: text.push_back(ChDot);
            2: begin
                text.push_back(ChDot);
                repeat ($urandom_range(1, 6)) text.push_back(8'(ChZero + $urandom_range(9)));
            end
            3: begin
                text.push_back(ChDot);
                text.push_back(ChStar);
            end
            default: ;
        endcase
        case ($urandom_range(4))
            1: text.push_back(ChLowH);
            2: begin
                text.push_back(ChLowH);
                text.push_back(ChLowH);
            end
            3: text.push_back(ChLowL);
            4: begin
                text.push_back(ChLowL);
                text.push_back(ChLowL);
            end
            default: ;
        endcase
        if ($urandom_range(99) < 85) begin
            text.push_back(random_specifier());
        end else if ($urandom_range(1) != 0) begin
            text.push_back(8'($urandom_range(255)));
        end else begin
            text.push_back(ChNul);
        end
        // Break the syntax now and then
        if ($urandom_range(99) < 10) begin
            text[$urandom_range(text.size() - 1)] = 8'($urandom_range(255));
        end
        if ($urandom_range(99) < 8) begin
            case ($urandom_range(4))
                0:       text.insert($urandom_range(text.size()), ChStar);
                1:       text.insert($urandom_range(text.size()), ChDot);
                2:       text.insert($urandom_range(text.size()), ChLowL);
                3:       text.insert($urandom_range(text.size()), ChLowH);
                default: text.insert($urandom_range(text.size()),
                                     8'(ChZero + $urandom_range(9)));
            endcase
        end
        if ($urandom_range(99) < 5) begin
            void'(text.pop_back());
        end
        foreach (text[i]) begin
            beat.ch         = text[i];
            beat.star_value = (text[i] == ChStar) ? random_star() : $urandom;
            beat.first_char = (i == 0) ? 1'($urandom_range(1)) : ($urandom_range(99) < 3);
            send_beat(beat);
        end
    endtask

    initial begin
        t_fsp_in     nul_beat;
        int unsigned phase_end;
        items_sent        = 0;
        send_idle_pct     = 0;
        recv_stall_pct    = 0;
        pressure_requests = 0;
        in_if.valid <= 1'b0;
        in_if.data  <= '0;
        rst_n       <= 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: all flags, negative stars, saturation, length forms, bad endings
        send_text("0-# +*.*lld", 32'h8000_0000);
        send_text("98765hhx", $urandom);
        send_text(".*hc", 32'h7fff_ffff);
        send_text("p", $urandom);
        send_text("lll", $urandom);
        send_text("*5", 32'd7);
        nul_beat.ch         = ChNul;
        nul_beat.star_value = '0;
        nul_beat.first_char = 1'b1;
        send_beat(nul_beat);

        // Random: free flow with one long hold-off, then the idle mixes
        pressure_requests++;
        phase_end = items_sent + PhaseItems;
        while (items_sent < phase_end) send_random_spec();

        send_idle_pct = 74;
        phase_end = items_sent + PhaseItems;
        while (items_sent < phase_end) send_random_spec();

        send_idle_pct  = 0;
        recv_stall_pct = 74;
        phase_end = items_sent + PhaseItems;
        while (items_sent < phase_end) send_random_spec();

        send_idle_pct  = 30;
        recv_stall_pct = 30;
        phase_end = items_sent + PhaseItems;
        while (items_sent < phase_end) send_random_spec();

        // Drain outstanding results, then let the pipeline settle
        in_if.valid   <= 1'b0;
        recv_stall_pct = 0;
        while (pending != 0) begin
            @(posedge clk);
        end
        repeat (TailCycles) @(posedge clk);

        if (fail_count == 0 && pending == 0) begin
            $display("tb_format_spec_parser: PASS");
        end else begin
            $display("tb_format_spec_parser: FAIL");
        end
        $finish;
    end

endmodule
